// ----- src/fmr_pkg.sv -----
// Shared types and constants for the framed message receiver.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmr_pkg;

  // Payload buffer size and the largest accepted declared length
  localparam int BUF_BYTES = 64;
  localparam int MAX_LEN   = BUF_BYTES - 8;
  localparam int PTR_W     = $clog2(BUF_BYTES);
  localparam int LEN_W     = 6;
  localparam logic [7:0] SUM_INIT = 8'hFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_START_MARKER = 3'd0,
    CFG_END_MARKER   = 3'd1,
    CFG_OWN_ADDRESS  = 3'd2,
    CFG_SOURCE_A     = 3'd3,
    CFG_SOURCE_B     = 3'd4,
    CFG_SOURCE_C     = 3'd5,
    CFG_SOURCE_D     = 3'd6
  } cfg_idx_t;

  // Receiver phases
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_SOURCE,
    ST_COUNT,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DATA,
    ST_CHECK,
    ST_TAIL,
    ST_DRAIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_frame;   // reset position, sum and zero flag
    logic ld_source;   // capture sender code
    logic ld_count;    // capture message count byte
    logic ld_len_hi;   // capture length high byte
    logic ld_len_lo;   // capture length low byte
    logic data_wr;     // store one payload byte
    logic start_drain; // rewind the read pointer
    logic drain;       // release stored payload
  } fmr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_start;    // word equals start marker
    logic is_end;      // word equals end marker
    logic addr_match;  // word equals own address
    logic src_match;   // word equals one of the sender ids
    logic len_ok;      // declared length at most MAX_LEN
    logic last_pos;    // this payload word completes the payload
    logic sum_match;   // word equals running checksum
    logic last_load;   // final payload word moves to the output
  } fmr_sts_t;

endpackage

`default_nettype wire

// ----- src/fmr_ctrl.sv -----
// Frame parser controller: phase state machine issuing datapath commands.
// Depends on fmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmr_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_accept,
  input  fmr_pkg::fmr_sts_t  sts,
  output fmr_pkg::fmr_cmd_t  cmd,
  output logic               in_ready
);
  import fmr_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r != ST_DRAIN);
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.clr_frame = 1'b1;
          if (sts.is_start) state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        if (in_accept) state_nxt = sts.addr_match ? ST_SOURCE : ST_IDLE;
      end
      ST_SOURCE: begin
        if (in_accept) begin
          cmd.ld_source = 1'b1;
          state_nxt = sts.src_match ? ST_COUNT : ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (in_accept) begin
          cmd.ld_count = 1'b1;
          state_nxt = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        if (in_accept) begin
          cmd.ld_len_hi = 1'b1;
          state_nxt = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        if (in_accept) begin
          cmd.ld_len_lo = 1'b1;
          state_nxt = sts.len_ok ? ST_DATA : ST_IDLE;
        end
      end
      ST_DATA: begin
        if (in_accept) begin
          cmd.data_wr = 1'b1;
          // Final byte wins over marker checks
          if (sts.last_pos) begin
            state_nxt = ST_CHECK;
          end else if (sts.is_start) begin
            cmd.clr_frame = 1'b1;
            state_nxt = ST_ADDR;
          end else if (sts.is_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CHECK: begin
        if (in_accept) state_nxt = sts.sum_match ? ST_TAIL : ST_IDLE;
      end
      ST_TAIL: begin
        if (in_accept) begin
          if (sts.is_end) begin
            cmd.start_drain = 1'b1;
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        cmd.drain = 1'b1;
        if (sts.last_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
    sts.last_load |=> state_r == ST_IDLE)
    else $error("drain did not end after final word");

  a_drain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && !sts.last_load) |=> state_r == ST_DRAIN)
    else $error("drain left before final word");

  a_drain_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_drain |=> state_r == ST_DRAIN)
    else $error("good frame did not start drain");

endmodule

`default_nettype wire

// ----- src/fmr_datapath.sv -----
// Frame parser datapath: config registers, header capture, checksum,
// payload buffer and output register. Depends on fmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmr_datapath (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_addr,
  input  wire  [7:0]         cfg_data,
  input  wire  [7:0]         rx_byte,
  input  fmr_pkg::fmr_cmd_t  cmd,
  output fmr_pkg::fmr_sts_t  sts,
  input  wire                out_ready,
  output logic               out_valid,
  output logic [7:0]         out_payload,
  output logic               out_last,
  output logic [1:0]         out_source,
  output logic [7:0]         out_count,
  output logic [fmr_pkg::LEN_W-1:0] out_length
);
  import fmr_pkg::*;

  logic [7:0] start_r, end_r, addr_r, src_a_r, src_b_r, src_c_r, src_d_r;
  logic [7:0] sum_r;
  logic       zero_r;
  logic [PTR_W-1:0] pos_r;
  logic       hi_nz_r;
  logic [LEN_W-1:0] len_r;
  logic [1:0] source_r, source_nxt;
  logic       src_hit;
  logic [7:0] count_r;
  logic [7:0] mem [BUF_BYTES];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [7:0] rd_q_r;
  logic       out_valid_r;
  logic [7:0] out_payload_r;
  logic       out_last_r;
  logic [1:0] out_source_r;
  logic [7:0] out_count_r;
  logic [LEN_W-1:0] out_length_r;
  logic       load;
  logic       zero_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 8'd2;
      end_r   <= 8'd3;
      addr_r  <= 8'd0;
      src_a_r <= 8'd0;
      src_b_r <= 8'd0;
      src_c_r <= 8'd0;
      src_d_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START_MARKER: start_r <= cfg_data;
        CFG_END_MARKER:   end_r   <= cfg_data;
        CFG_OWN_ADDRESS:  addr_r  <= cfg_data;
        CFG_SOURCE_A:     src_a_r <= cfg_data;
        CFG_SOURCE_B:     src_b_r <= cfg_data;
        CFG_SOURCE_C:     src_c_r <= cfg_data;
        CFG_SOURCE_D:     src_d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sender lookup, lowest code wins
  always_comb begin
    source_nxt = 2'd0;
    src_hit    = 1'b1;
    if (rx_byte == src_a_r)      source_nxt = 2'd0;
    else if (rx_byte == src_b_r) source_nxt = 2'd1;
    else if (rx_byte == src_c_r) source_nxt = 2'd2;
    else if (rx_byte == src_d_r) source_nxt = 2'd3;
    else                         src_hit = 1'b0;
  end

  // Status toward the controller
  assign load           = cmd.drain && (!out_valid_r || out_ready);
  assign sts.is_start   = (rx_byte == start_r);
  assign sts.is_end     = (rx_byte == end_r);
  assign sts.addr_match = (rx_byte == addr_r);
  assign sts.src_match  = src_hit;
  assign sts.len_ok     = !hi_nz_r && (rx_byte <= 8'(MAX_LEN));
  assign sts.last_pos   = ((pos_r + PTR_W'(1)) >= PTR_W'(len_r));
  assign sts.sum_match  = (rx_byte == sum_r);
  assign sts.last_load  = load && (rd_ptr_r == PTR_W'(len_r - LEN_W'(1)));

  assign zero_nxt = zero_r || (rx_byte == 8'd0);

  // Frame control: position, checksum, zero flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= SUM_INIT;
      zero_r <= 1'b0;
    end else if (cmd.clr_frame) begin
      pos_r  <= '0;
      sum_r  <= SUM_INIT;
      zero_r <= 1'b0;
    end else if (cmd.data_wr) begin
      pos_r  <= pos_r + PTR_W'(1);
      zero_r <= zero_nxt;
      if (!zero_nxt) sum_r <= sum_r + rx_byte;
    end
  end

  // Header capture
  always_ff @(posedge clk) begin
    if (cmd.ld_source && src_hit) source_r <= source_nxt;
    if (cmd.ld_count)  count_r <= rx_byte;
    if (cmd.ld_len_hi) hi_nz_r <= (rx_byte != 8'd0);
    // A zero length still carries one payload word
    if (cmd.ld_len_lo) len_r <= (rx_byte == 8'd0) ? LEN_W'(1) : rx_byte[LEN_W-1:0];
  end

  // Read pointer for the release
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.start_drain) rd_ptr_nxt = '0;
    else if (load)       rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Payload buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.data_wr) mem[pos_r] <= rx_byte;
    rd_q_r <= mem[rd_ptr_nxt];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_payload_r <= rd_q_r;
      out_last_r    <= sts.last_load;
      out_source_r  <= source_r;
      out_count_r   <= count_r;
      out_length_r  <= len_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;
  assign out_source  = out_source_r;
  assign out_count   = out_count_r;
  assign out_length  = out_length_r;

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.data_wr |-> PTR_W'(pos_r) < PTR_W'(len_r))
    else $error("payload write beyond declared length");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> rd_ptr_r < PTR_W'(len_r))
    else $error("payload read beyond declared length");

  a_len_sane: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain |-> (len_r != '0 && len_r <= LEN_W'(MAX_LEN)))
    else $error("release with bad length");

endmodule

`default_nettype wire

// ----- src/framed_message_receiver_unit.sv -----
// Top level of the framed message receiver: stream ports and config port.
// Instantiates fmr_ctrl and fmr_datapath; depends on fmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream frame receiver. Each input word is one received byte; the
// input stays ready while a frame is being parsed: start marker, own
// address, sender id, message count, 16-bit length, payload, checksum,
// end marker. A frame that passes every check releases its payload words
// (1 to 56) on the output stream, with tlast on the final word and the
// sender code on tuser. After the end byte is taken, the input stays not
// ready until all n payload words have moved into the output register.
// The payload buffer has one read port and delivers one word per cycle
// while the output is not stalled. Configuration is written through
// cfg_we/cfg_addr/cfg_data while no frame is in flight.
module framed_message_receiver_unit (
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_addr,
  input  wire  [7:0]  cfg_data,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  // output stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [7:0] payload_byte, [15:8] message_count,
                                  // [21:16] payload_length, [23:22] zero
  output logic        out_tlast,  // last_byte
  output logic [1:0]  out_tuser   // [1:0] source_code
);
  import fmr_pkg::*;

  fmr_cmd_t         cmd;
  fmr_sts_t         sts;
  logic             in_accept;
  logic [7:0]       payload;
  logic [7:0]       count;
  logic [LEN_W-1:0] length;

  assign in_accept = in_tvalid && in_tready;

  fmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_tready)
  );

  fmr_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .rx_byte     (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_payload (payload),
    .out_last    (out_tlast),
    .out_source  (out_tuser),
    .out_count   (count),
    .out_length  (length)
  );

  // Pack the result word
  assign out_tdata = {2'b00, length, count, payload};

endmodule

`default_nettype wire
